### hw/rtl/msort_pkg.sv
// msort_pkg: shared types and constants of the merge sorter
// request and response payload structs, data width and default capacity
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int MAX_ITEMS_DEFAULT = 64;

   // one request: an element of the data set
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_item;
   } req_type;

   // one response: the next element in ascending order
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_result;
      logic                         overflow;
   } rsp_type;

endpackage

`default_nettype wire

### hw/rtl/msort_ram.sv
// msort_ram: generic simple dual-port ram, one write port, two read ports
// read data registered, no reset on the array
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module msort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic      [WIDTH-1:0]         rd_data0,
   output logic      [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule

`default_nettype wire

### hw/rtl/merge_sorter.sv
// merge_sorter: stable ascending merge sort of signed 32-bit values
// depends on msort_pkg (payload types, constants) and msort_ram (buffers)
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  Requests enter on req_payload when start is high and busy is low. Each
//  request stores one value; a request with last_item set ends the data set
//  and starts the sort. Values beyond MAX_ITEMS are dropped and every result
//  of that data set then carries overflow.
//  Results leave on rsp_payload, one per cycle, each valid for exactly the
//  cycle in which rsp_strobe is high; last_result marks the final one. The
//  receiver cannot stall, so results are never held.
//  Loading stores each request as it is taken. The sort is a bottom-up
//  merge between two buffer rams and runs ceil(log2 n) passes; each pass
//  has a pass setup step and a run end step, a run setup step per run pair
//  and, per element, a read of both run heads and then a compare and write,
//  the read step set by the registered read of the buffer rams; one more
//  pass setup step ends the sort, and output reads one result per element.
//  busy is high from the cycle after the last request until the final result
//  read is issued; a new request may be taken while the final result shows.
//  Reset (synchronous, active high) empties the buffer and clears the drop
//  flag; buffer contents are not cleared and need no clearing pass.

module merge_sorter #(
   parameter int MAX_ITEMS = msort_pkg::MAX_ITEMS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire msort_pkg::req_type req_payload,
   output logic                   rsp_strobe,
   output msort_pkg::rsp_type     rsp_payload
);

   localparam int DW = msort_pkg::DATA_WIDTH;
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int XW = CW + 1;

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_PASS  = 3'd1;
   localparam logic [2:0] S_RUN   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_MERGE = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic          src_sel_ff, src_sel_in;   // 0: sorted data in buffer a
   logic [XW-1:0] width_ff, width_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          accept;
   logic          load_wr;
   logic [CW-1:0] k_plus;
   logic [XW:0]   mid_sum;
   logic [XW:0]   hi_sum;
   logic [CW-1:0] mid_calc;
   logic [CW-1:0] hi_calc;
   logic          take_left;
   logic [DW-1:0] left_data;
   logic [DW-1:0] right_data;
   logic [DW-1:0] merge_data;

   logic          a_wr_en, b_wr_en;
   logic [AW-1:0] a_wr_addr;
   logic [DW-1:0] a_wr_data;
   logic [AW-1:0] rd_addr0, rd_addr1;
   logic [DW-1:0] a_rd0, a_rd1, b_rd0, b_rd1;

   assign busy   = (state_ff != S_LOAD);
   assign accept = start && !busy;
   assign load_wr = accept && (count_ff < CW'(MAX_ITEMS));
   assign k_plus = k_ff + CW'(1);

   // run bounds, clamped to the element count
   assign mid_sum  = {2'b00, lo_ff} + {1'b0, width_ff};
   assign hi_sum   = {2'b00, lo_ff} + {width_ff, 1'b0};
   assign mid_calc = (mid_sum > (XW+1)'(count_ff)) ? count_ff : mid_sum[CW-1:0];
   assign hi_calc  = (hi_sum > (XW+1)'(count_ff)) ? count_ff : hi_sum[CW-1:0];

   // merge decision on the registered run heads, left run wins ties
   assign left_data  = src_sel_ff ? b_rd0 : a_rd0;
   assign right_data = src_sel_ff ? b_rd1 : a_rd1;
   assign take_left  = (i_ff < mid_ff) &&
                       ((j_ff >= hi_ff) || ($signed(left_data) <= $signed(right_data)));
   assign merge_data = take_left ? left_data : right_data;

   // buffer ports
   assign rd_addr0  = (state_ff == S_OUT) ? k_ff[AW-1:0] : i_ff[AW-1:0];
   assign rd_addr1  = j_ff[AW-1:0];
   assign a_wr_en   = load_wr || ((state_ff == S_MERGE) && src_sel_ff);
   assign a_wr_addr = load_wr ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign a_wr_data = load_wr ? DW'(req_payload.value) : merge_data;
   assign b_wr_en   = (state_ff == S_MERGE) && !src_sel_ff;

   msort_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ITEMS)
   ) u_buffer_a (
      .clock    (clock),
      .wr_en    (a_wr_en),
      .wr_addr  (a_wr_addr),
      .wr_data  (a_wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (a_rd0),
      .rd_data1 (a_rd1)
   );

   msort_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_ITEMS)
   ) u_buffer_b (
      .clock    (clock),
      .wr_en    (b_wr_en),
      .wr_addr  (k_ff[AW-1:0]),
      .wr_data  (merge_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (b_rd0),
      .rd_data1 (b_rd1)
   );

   // sequencer: load, merge passes, output
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      src_sel_in    = src_sel_ff;
      width_in      = width_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      hi_in         = hi_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      rsp_strobe_in = 1'b0;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (load_wr) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_payload.last_item) begin
                  width_in   = XW'(1);
                  src_sel_in = 1'b0;
                  state_in   = S_PASS;
               end
            end
         end
         S_PASS: begin
            lo_in = '0;
            k_in  = '0;
            if (width_ff < XW'(count_ff)) begin
               state_in = S_RUN;
            end else begin
               state_in = S_OUT;
            end
         end
         S_RUN: begin
            if (lo_ff >= count_ff) begin
               src_sel_in = !src_sel_ff;
               width_in   = {width_ff[XW-2:0], 1'b0};
               state_in   = S_PASS;
            end else begin
               mid_in   = mid_calc;
               hi_in    = hi_calc;
               i_in     = lo_ff;
               j_in     = mid_calc;
               k_in     = lo_ff;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_MERGE;
         end
         S_MERGE: begin
            if (take_left) begin
               i_in = i_ff + CW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
            k_in = k_plus;
            if (k_plus == hi_ff) begin
               lo_in    = hi_ff;
               state_in = S_RUN;
            end else begin
               state_in = S_READ;
            end
         end
         S_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = (k_plus == count_ff);
            rsp_ovf_in    = dropped_ff;
            k_in          = k_plus;
            if (k_plus == count_ff) begin
               count_in   = '0;
               dropped_in = 1'b0;
               state_in   = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // run pointers and response fields
   always_ff @(posedge clock) begin
      src_sel_ff  <= src_sel_in;
      width_ff    <= width_in;
      lo_ff       <= lo_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // response, data straight from the registered ram read
   assign rsp_strobe               = rsp_strobe_ff;
   assign rsp_payload.sorted_value = $signed(src_sel_ff ? b_rd0 : a_rd0);
   assign rsp_payload.last_result  = rsp_last_ff;
   assign rsp_payload.overflow     = rsp_ovf_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("element count beyond capacity");

   a_merge_in_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> (k_ff < hi_ff) && (mid_ff <= hi_ff))
      else $error("merge write outside its run");

   a_merge_bookkeeping: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE) |-> ((i_ff + j_ff) == (k_ff + mid_ff)))
      else $error("run heads disagree with write pointer");

   a_strobe_from_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_OUT))
      else $error("response without output read");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.last_result) |-> (state_ff == S_LOAD))
      else $error("final response while still sorting");

endmodule

`default_nettype wire
